// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and arithmetic helpers for the pure pursuit
// steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int PATH_DEPTH_DEF = 128;
  localparam int WINDOW_MAX_DEF = 64;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_LOOKAHEAD = 2'd0,
    CFG_GAIN      = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_PATH_LEN  = 2'd3
  } cfg_idx_t;

  localparam logic [30:0] LOOKAHEAD_RST = 31'd98304;
  localparam logic [15:0] GAIN_RST      = 16'd819;
  localparam logic [6:0]  WINDOW_RST    = 7'd25;
  localparam logic [7:0]  PATH_LEN_RST  = 8'd100;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POSE = 1'b1;

  localparam logic signed [15:0] Q_ONE      = 16'sd16384;
  localparam logic signed [31:0] R_ONE      = 32'sd268435456;
  localparam logic [15:0]        STEER_HALF = 16'd2048;
  localparam logic [15:0]        STEER_MAX  = 16'hFFFF;
  localparam logic [9:0]         SPEED_FAST = 10'd256;
  localparam logic [9:0]         SPEED_SLOW = 10'd128;

  typedef struct packed {
    logic               kind;
    logic [6:0]         waypoint_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               transform_ok;
  } in_item_t;

  typedef struct packed {
    logic [15:0] steering;
    logic [9:0]  speed;
    logic [6:0]  target_slot;
    logic        target_found;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_SMOD, ST_SCAN, ST_ROTQ, ST_ROTM, ST_ROTX,
    ST_ROTY, ST_ROTW, ST_MAG, ST_ROOT, ST_WAIT, ST_DONE
  } pps_state_t;

  typedef enum logic [2:0] {
    RD_IDLE, RD_SQRT, RD_DIVI, RD_DIV, RD_DONE
  } rd_state_t;

  // Saturate a quaternion component to -1.0 .. 1.0
  function automatic logic signed [15:0] sat_q(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v > Q_ONE) r = Q_ONE;
    else if (v < -Q_ONE) r = -Q_ONE;
    else r = v;
    return r;
  endfunction

  // Magnitude of a signed 32-bit value
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  // Round Q4.28 x Q16.16 sum to Q16.16, add shift, saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] p0,
                                                   input logic signed [63:0] p1,
                                                   input logic signed [31:0] sh);
    logic signed [65:0] s;
    logic signed [37:0] t;
    logic signed [38:0] v;
    logic signed [31:0] r;
    s = 66'(p0) + 66'(p1) + 66'sd134217728;
    t = 38'(s >>> 28);
    v = 39'(t) + 39'(sh);
    if (v > 39'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -39'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

// ===== hdl/pps_root_div.sv =====
// ----------------------------------------------------------------------------
// pps_root_div
// Floor square root of the squared target distance, one bit pair a cycle,
// then a restoring divide of the rounded numerator, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pps_root_div
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] sum,
  input  logic [48:0] num,
  output logic        done,
  output logic [15:0] steer
);

  rd_state_t   state, state_next;
  logic [63:0] v, r, bitp, rb;
  logic [4:0]  iter;
  logic [31:0] d;
  logic [49:0] n, rem;
  logic [46:0] dsh;
  logic [15:0] q;

  assign rb    = r + bitp;
  assign d     = r[31:0];
  assign n     = {1'b0, num} + 50'(d >> 1);
  assign steer = q;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      RD_IDLE: if (start) state_next = RD_SQRT;
      RD_SQRT: if (iter == 5'd0) state_next = RD_DIVI;
      RD_DIVI: begin
        if (d == 32'd0 || n >= {2'b0, d, 16'b0}) state_next = RD_DONE;
        else state_next = RD_DIV;
      end
      RD_DIV:  if (iter == 5'd0) state_next = RD_DONE;
      RD_DONE: state_next = RD_IDLE;
      default: state_next = RD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == RD_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= RD_IDLE;
    else state <= state_next;
  end

  // Datapath: root iterations, then quotient bits
  always_ff @(posedge clk) begin
    unique case (state)
      RD_IDLE: begin
        v    <= sum;
        r    <= 64'd0;
        bitp <= 64'd1 << 62;
        iter <= 5'd31;
      end
      RD_SQRT: begin
        if (v >= rb) begin
          v <= v - rb;
          r <= (r >> 1) + bitp;
        end else begin
          r <= r >> 1;
        end
        bitp <= bitp >> 2;
        iter <= iter - 5'd1;
      end
      RD_DIVI: begin
        rem  <= n;
        dsh  <= {d, 15'b0};
        iter <= 5'd15;
        if (d == 32'd0) q <= 16'd0;
        else if (n >= {2'b0, d, 16'b0}) q <= STEER_MAX;
        else q <= 16'd0;
      end
      RD_DIV: begin
        if (rem >= 50'(dsh)) begin
          rem <= rem - 50'(dsh);
          q   <= {q[14:0], 1'b1};
        end else begin
          q   <= {q[14:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        iter <= iter - 5'd1;
      end
      RD_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/pure_pursuit_steering_top.sv =====
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top
// Pure pursuit steering: waypoint store, windowed lookahead search,
// quaternion transform into the car frame and steering/speed command.
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   in      | in_valid in_ready in_item        | load or pose item
//   out     | out_valid out_ready out_item     | one result per pose item
//   cfg     | cfg_valid cfg_ready cfg_index    | register write, always ready
//           | cfg_data                         |
//
// ST_LOAD takes PATH_DEPTH off a load item's index until it is in range, then
// writes the store. A pose item goes through one waypoint read per cycle from
// the store, a 3-stage distance pipeline and a step to close the scan, 5
// transform steps (left out without a valid transform), 32 root and 16 divide
// iterations (the divide is left out when the result saturates or the distance
// is zero); a path length cut below the search start adds a start-index
// reduction. No item is taken until the result is registered.
// Reset is synchronous and clears control, the search start and the targets;
// the store is undefined until written. A result waits in the output register
// and the block keeps taking load items while it waits.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_top
  import pps_pkg::*;
#(
  parameter int PATH_DEPTH = PATH_DEPTH_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int LW = $clog2(PATH_DEPTH + 1);
  localparam int WW = $clog2(WINDOW_MAX + 1);

  // Configuration registers
  logic [30:0] lookahead;
  logic [15:0] gain;
  logic [6:0]  window;
  logic [7:0]  path_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LOOKAHEAD_RST;
      gain      <= GAIN_RST;
      window    <= WINDOW_RST;
      path_len  <= PATH_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD: lookahead <= cfg_data[30:0];
        CFG_GAIN:      gain      <= cfg_data[15:0];
        CFG_WINDOW:    window    <= cfg_data[6:0];
        CFG_PATH_LEN:  path_len  <= cfg_data[7:0];
      endcase
    end
  end

  // Effective path length and window
  logic [LW-1:0] len_eff;
  logic [WW-1:0] win_eff;

  always_comb begin
    if (path_len == 8'd0) len_eff = LW'(1);
    else if (32'(path_len) > PATH_DEPTH) len_eff = LW'(PATH_DEPTH);
    else len_eff = LW'(path_len);
    if (32'(window) > WINDOW_MAX) win_eff = WW'(WINDOW_MAX);
    else win_eff = WW'(window);
  end

  pps_state_t state, state_next;

  // Captured item
  logic [6:0]         lidx;
  logic signed [31:0] px, py, sx, sy, lx, ly;
  logic signed [15:0] qw, qx, qy, qz;
  logic               tok;
  logic [61:0]        l2;

  // Persistent state
  logic [AW-1:0]      search_start, ss_work;
  logic signed [31:0] map_x, map_y, car_x, car_y;

  // Scan control and pipeline
  logic [AW-1:0]      idx, s1_idx, s2_idx, s3_idx, best_idx;
  logic [WW-1:0]      cnt;
  logic               s1_v, s2_v, s3_v;
  logic [63:0]        rd_data;
  logic [31:0]        dx, dy;
  logic signed [31:0] s2_x, s2_y, s3_x, s3_y, best_x, best_y;
  logic [63:0]        a_sq, b_sq;
  logic [64:0]        cur, best;
  logic               found, qual, better;
  logic               issue, scan_end, load_wrap;
  logic signed [32:0] ddx, ddy;

  // Transform and magnitude
  logic signed [31:0] q_ww, q_xx, q_yy, q_xy, q_wz;
  logic signed [31:0] r00, r01, r10, r11;
  logic signed [63:0] p0, p1;
  logic [31:0]        ax, ay;
  logic [63:0]        m_a, m_b;
  logic [48:0]        num;
  logic               root_start, root_done;
  logic [15:0]        root_steer;

  // Waypoint store: {x, y} per slot
  logic [63:0] mem [PATH_DEPTH];
  logic        mem_we;

  assign load_wrap = 32'(lidx) >= PATH_DEPTH;
  assign issue     = (state == ST_SCAN) && (cnt != win_eff);
  assign scan_end  = (state == ST_SCAN) && (cnt == win_eff) && !s1_v && !s2_v && !s3_v;

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(lidx)] <= {lx, ly};
    if (issue)  rd_data <= mem[idx];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = (in_item.kind == KIND_LOAD) ? ST_LOAD : ST_SMOD;
      end
      ST_LOAD: if (!load_wrap) state_next = ST_IDLE;
      ST_SMOD: if (32'(ss_work) < 32'(len_eff)) state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = tok ? ST_ROTQ : ST_MAG;
      ST_ROTQ: state_next = ST_ROTM;
      ST_ROTM: state_next = ST_ROTX;
      ST_ROTX: state_next = ST_ROTY;
      ST_ROTY: state_next = ST_ROTW;
      ST_ROTW: state_next = ST_MAG;
      ST_MAG:  state_next = ST_ROOT;
      ST_ROOT: state_next = ST_WAIT;
      ST_WAIT: if (root_done) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready   = (state == ST_IDLE);
    mem_we     = (state == ST_LOAD) && !load_wrap;
    root_start = (state == ST_ROOT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Distance compare at the end of the pipeline
  assign cur    = {1'b0, a_sq} + {1'b0, b_sq};
  assign qual   = cur >= {3'b0, l2};
  assign better = !found || (cur < best);
  assign ddx    = 33'(signed'(rd_data[63:32])) - 33'(px);
  assign ddy    = 33'(signed'(rd_data[31:0])) - 33'(py);
  assign ax     = abs32(car_x);
  assign ay     = abs32(car_y);

  // Capture items and advance the scan
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lidx    <= in_item.waypoint_index;
      lx      <= in_item.coord_x;
      ly      <= in_item.coord_y;
      px      <= in_item.coord_x;
      py      <= in_item.coord_y;
      sx      <= in_item.shift_x;
      sy      <= in_item.shift_y;
      qw      <= sat_q(in_item.rot_w);
      qx      <= sat_q(in_item.rot_x);
      qy      <= sat_q(in_item.rot_y);
      qz      <= sat_q(in_item.rot_z);
      tok     <= in_item.transform_ok;
      l2      <= lookahead * lookahead;
      ss_work <= search_start;
    end
    if (state == ST_LOAD && load_wrap) lidx <= lidx - 7'(PATH_DEPTH);
    if (state == ST_SMOD) begin
      if (32'(ss_work) >= 32'(len_eff)) ss_work <= ss_work - AW'(len_eff);
      idx   <= ss_work;
      cnt   <= '0;
      found <= 1'b0;
    end
    // Issue one read a cycle, wrap at the path length
    if (issue) begin
      cnt    <= cnt + WW'(1);
      s1_idx <= idx;
      if (32'(idx) + 1 == 32'(len_eff)) idx <= '0;
      else idx <= idx + AW'(1);
    end
    // Stage 2: absolute differences
    s2_idx <= s1_idx;
    s2_x   <= signed'(rd_data[63:32]);
    s2_y   <= signed'(rd_data[31:0]);
    dx     <= ddx[32] ? 32'(-ddx) : 32'(ddx);
    dy     <= ddy[32] ? 32'(-ddy) : 32'(ddy);
    // Stage 3: squares
    s3_idx <= s2_idx;
    s3_x   <= s2_x;
    s3_y   <= s2_y;
    a_sq   <= dx * dx;
    b_sq   <= dy * dy;
    // Stage 4: keep the first nearest qualifying waypoint
    if (s3_v && qual && better) begin
      found    <= 1'b1;
      best     <= cur;
      best_idx <= s3_idx;
      best_x   <= s3_x;
      best_y   <= s3_y;
    end
    // Transform steps
    if (state == ST_ROTQ) begin
      q_ww <= qw * qw;
      q_xx <= qx * qx;
      q_yy <= qy * qy;
      q_xy <= qx * qy;
      q_wz <= qw * qz;
    end
    if (state == ST_ROTM) begin
      r00 <= ((q_ww + q_xx) <<< 1) - R_ONE;
      r01 <= (q_xy - q_wz) <<< 1;
      r10 <= (q_xy + q_wz) <<< 1;
      r11 <= ((q_ww + q_yy) <<< 1) - R_ONE;
    end
    if (state == ST_ROTX) begin
      p0 <= r00 * map_x;
      p1 <= r01 * map_y;
    end
    if (state == ST_ROTY) begin
      p0 <= r10 * map_x;
      p1 <= r11 * map_y;
    end
    // Magnitude squares and numerator
    if (state == ST_MAG) begin
      m_a <= ax * ax;
      m_b <= ay * ay;
      num <= {48'(gain) * 48'(ay), 1'b0};
    end
  end

  // Control state and the target registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      search_start <= '0;
      map_x        <= '0;
      map_y        <= '0;
      car_x        <= '0;
      car_y        <= '0;
      out_valid    <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (scan_end && found) begin
        search_start <= best_idx;
        map_x        <= best_x;
        map_y        <= best_y;
      end
      if (state == ST_ROTY) car_x <= round_sat(p0, p1, sx);
      if (state == ST_ROTW) car_y <= round_sat(p0, p1, sy);
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_item.steering     <= root_steer;
      out_item.speed        <= (root_steer > STEER_HALF) ? SPEED_FAST : SPEED_SLOW;
      out_item.target_slot  <= 7'(search_start);
      out_item.target_found <= found;
    end
  end

  pps_root_div u_root_div (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .sum   (m_a + m_b),
    .num   (num),
    .done  (root_done),
    .steer (root_steer)
  );

endmodule
